@@ rtl/core/owbm_pkg.sv @@
// Shared types and constants for the single-wire bus master.
// Holds the command codes, the configuration register map and the item structs.
// No dependencies; every other file of the block but the port checker imports this package.
package owbm_pkg;

    // Configuration register map
    localparam int CFG_W     = 10;
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ONE_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ZERO_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd7;

    localparam logic [CFG_W-1:0] CFG_DEFAULTS [CFG_COUNT] = '{
        10'd480, 10'd70, 10'd410, 10'd6, 10'd60, 10'd70, 10'd3, 10'd12
    };

    // Fixed length of the tail that closes a read slot
    localparam logic [CFG_W-1:0] READ_TAIL_TICKS = 10'd50;

    // Bits per byte command
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Mode codes as they arrive on the input channel
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_RESET = 3'd1;
    localparam logic [2:0] MODE_WBYTE = 3'd2;
    localparam logic [2:0] MODE_RBYTE = 3'd3;
    localparam logic [2:0] MODE_WBIT  = 3'd4;
    localparam logic [2:0] MODE_RBIT  = 3'd5;

    // Classified item kind
    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_RESET,
        CMD_WBYTE,
        CMD_RBYTE,
        CMD_WBIT,
        CMD_RBIT
    } cmd_t;

    // One classified input item
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       line;
    } item_t;

    // One result item
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_value;
        logic       rejected;
    } result_t;

endpackage

@@ rtl/core/owbm_front.sv @@
// Front end of the single-wire bus master: classifies each incoming item.
// Depends on owbm_pkg for the mode and command codes.
module owbm_front
    import owbm_pkg::*;
(
    input  logic [2:0] mode,
    input  logic [7:0] data_byte,
    input  logic       line_level,
    output item_t      item
);

    // Map the raw mode to a command; unused codes count as a tick.
    always_comb
    begin
        item.data = data_byte;
        item.line = line_level;
        case (mode)
            MODE_TICK:  item.cmd = CMD_TICK;
            MODE_RESET: item.cmd = CMD_RESET;
            MODE_WBYTE: item.cmd = CMD_WBYTE;
            MODE_RBYTE: item.cmd = CMD_RBYTE;
            MODE_WBIT:  item.cmd = CMD_WBIT;
            MODE_RBIT:  item.cmd = CMD_RBIT;
            default:    item.cmd = CMD_TICK;
        endcase
    end

endmodule

@@ rtl/core/owbm_queue.sv @@
// Two-entry queue between the front end and the bus sequencer.
// Depends on owbm_pkg for the item struct.
module owbm_queue
    import owbm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_en,
    output item_t pop_item
);

    localparam int DEPTH   = 2;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               push;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign push       = push_valid && push_ready;
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && pop_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/owbm_back.sv @@
// Bus sequencer of the single-wire bus master: timing registers, phase state
// and the result register. Depends on owbm_pkg for types and constants.
module owbm_back
    import owbm_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_pop,
    output logic                 res_valid,
    output result_t              res,
    input  logic                 res_ready
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    // Phase codes
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_RST_LOW   = 3'd1;
    localparam logic [2:0] PH_RST_WAIT  = 3'd2;
    localparam logic [2:0] PH_RST_TAIL  = 3'd3;
    localparam logic [2:0] PH_SLOT_LOW  = 3'd4;
    localparam logic [2:0] PH_SLOT_WAIT = 3'd5;
    localparam logic [2:0] PH_SLOT_TAIL = 3'd6;

    // Operation kinds
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RBYTE = 2'd2;
    localparam logic [1:0] OP_RBIT  = 2'd3;

    function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

    logic [CFG_W-1:0]       cfg_reg [CFG_COUNT];

    logic [2:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [7:0]             shift_data_reg, shift_data_next;
    logic [3:0]             bits_left_reg, bits_left_next;
    logic [1:0]             op_kind_reg, op_kind_next;
    logic                   presence_reg, presence_next;

    logic                   res_valid_reg;
    result_t                res_reg;
    result_t                res_next;

    logic                   busy;
    logic                   is_write;
    logic [CFG_W-1:0]       wr_low_len;
    logic [CFG_W-1:0]       low_len;
    logic [CFG_W-1:0]       wait_len;
    logic [CFG_W-1:0]       phase_len;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   expired;
    logic [7:0]             shift_right;
    logic [7:0]             sample_data;
    logic [3:0]             bits_dec;
    logic                   wait_end;
    logic                   bit_end;
    logic                   done;
    logic                   rej;

    // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                cfg_reg[i] <= CFG_DEFAULTS[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_idx] <= cfg_wdata;
        end
    end

    // Length of the current phase.
    assign busy       = (phase_reg != PH_IDLE);
    assign is_write   = (op_kind_reg == OP_WRITE);
    assign wr_low_len = at_least_one(shift_data_reg[0] ? cfg_reg[CFG_WRITE_ONE_LOW]
                                                       : cfg_reg[CFG_WRITE_ZERO_LOW]);
    assign low_len    = is_write ? wr_low_len : at_least_one(cfg_reg[CFG_READ_LOW]);

    always_comb
    begin
        if (is_write)
        begin
            wait_len = (cfg_reg[CFG_WRITE_SLOT] > wr_low_len)
                     ? (cfg_reg[CFG_WRITE_SLOT] - wr_low_len) : '0;
        end
        else
        begin
            wait_len = cfg_reg[CFG_READ_SAMPLE];
        end
    end

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:   phase_len = at_least_one(cfg_reg[CFG_RESET_LOW]);
            PH_RST_WAIT:  phase_len = at_least_one(cfg_reg[CFG_PRESENCE_WAIT]);
            PH_RST_TAIL:  phase_len = cfg_reg[CFG_RESET_TAIL];
            PH_SLOT_LOW:  phase_len = low_len;
            PH_SLOT_WAIT: phase_len = wait_len;
            PH_SLOT_TAIL: phase_len = READ_TAIL_TICKS;
            default:      phase_len = '0;
        endcase
    end

    // Tick arithmetic and the per-bit updates.
    assign tick_inc    = tick_count_reg + 1'b1;
    assign expired     = (CMP_W'(tick_inc) >= CMP_W'(phase_len));
    assign shift_right = {1'b0, shift_data_reg[7:1]};
    assign sample_data = (op_kind_reg == OP_RBIT) ? {7'b0, item.line}
                                                  : {item.line, shift_data_reg[7:1]};
    assign bits_dec    = bits_left_reg - 1'b1;

    // Next state for one item; zero-length phases close on the same item.
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        shift_data_next = shift_data_reg;
        bits_left_next  = bits_left_reg;
        op_kind_next    = op_kind_reg;
        presence_next   = presence_reg;
        wait_end        = 1'b0;
        bit_end         = 1'b0;
        done            = 1'b0;
        rej             = 1'b0;

        if (item.cmd != CMD_TICK)
        begin
            if (busy)
            begin
                rej = 1'b1;
            end
            else
            begin
                tick_count_next = '0;
                case (item.cmd)
                    CMD_RESET:
                    begin
                        op_kind_next   = OP_RESET;
                        presence_next  = 1'b0;
                        bits_left_next = '0;
                        phase_next     = PH_RST_LOW;
                    end
                    CMD_WBYTE:
                    begin
                        op_kind_next    = OP_WRITE;
                        shift_data_next = item.data;
                        bits_left_next  = BYTE_BITS;
                        phase_next      = PH_SLOT_LOW;
                    end
                    CMD_RBYTE:
                    begin
                        op_kind_next    = OP_RBYTE;
                        shift_data_next = '0;
                        bits_left_next  = BYTE_BITS;
                        phase_next      = PH_SLOT_LOW;
                    end
                    CMD_WBIT:
                    begin
                        op_kind_next    = OP_WRITE;
                        shift_data_next = {7'b0, item.data[0]};
                        bits_left_next  = 4'd1;
                        phase_next      = PH_SLOT_LOW;
                    end
                    CMD_RBIT:
                    begin
                        op_kind_next    = OP_RBIT;
                        shift_data_next = '0;
                        bits_left_next  = 4'd1;
                        phase_next      = PH_SLOT_LOW;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (busy)
        begin
            tick_count_next = tick_inc;
            if (expired)
            begin
                tick_count_next = '0;
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        presence_next = ~item.line;
                        if (cfg_reg[CFG_RESET_TAIL] == '0)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RST_TAIL;
                        end
                    end
                    PH_RST_TAIL:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_SLOT_LOW:
                    begin
                        if (wait_len != '0)
                        begin
                            phase_next = PH_SLOT_WAIT;
                        end
                        else
                        begin
                            wait_end = 1'b1;
                        end
                    end
                    PH_SLOT_WAIT:
                    begin
                        wait_end = 1'b1;
                    end
                    PH_SLOT_TAIL:
                    begin
                        bit_end = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase

                // End of the release part: a write slot ends, a read samples.
                if (wait_end)
                begin
                    if (is_write)
                    begin
                        bit_end = 1'b1;
                    end
                    else
                    begin
                        shift_data_next = sample_data;
                        phase_next      = PH_SLOT_TAIL;
                    end
                end

                // End of a bit slot.
                if (bit_end)
                begin
                    if (is_write)
                    begin
                        shift_data_next = shift_right;
                    end
                    bits_left_next = bits_dec;
                    if (bits_dec == '0)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SLOT_LOW;
                    end
                end
            end
        end
    end

    // Result fields follow the state after the item.
    always_comb
    begin
        res_next.drive_low  = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
        res_next.busy_res   = (phase_next != PH_IDLE);
        res_next.done_res   = done;
        res_next.presence   = presence_next;
        res_next.read_value = (done && ((op_kind_next == OP_RBYTE) || (op_kind_next == OP_RBIT)))
                            ? shift_data_next : 8'd0;
        res_next.rejected   = rej;
    end

    // Take an item whenever the result register is free or being drained.
    assign item_pop = item_valid && (!res_valid_reg || res_ready);

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            shift_data_reg <= '0;
            bits_left_reg  <= '0;
            op_kind_reg    <= OP_RESET;
            presence_reg   <= 1'b0;
        end
        else if (item_pop)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            shift_data_reg <= shift_data_next;
            bits_left_reg  <= bits_left_next;
            op_kind_reg    <= op_kind_next;
            presence_reg   <= presence_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (item_pop)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/one_wire_bus_master_top.sv @@
// Single-wire bus master driven by one-microsecond ticks.
// Each input transaction is a tick or a command (s_tuser holds the mode).
// Each input transaction yields exactly one output transaction on the master
// side with the drive level, status flags and any read result.
// Configuration: cfg_we writes cfg_wdata into the timing register cfg_idx;
// write only while no transaction is outstanding.
// Each accepted transaction is registered in a queue entry and then in the result register.
// Throughput: one transaction per cycle while m_tready is high; the phase update
// in the sequencer is combinational, so ticks and commands stream at full rate.
// A two-entry queue between classifier and sequencer and a result register
// let both sides stall independently; when m_tready is low the result holds,
// the queue fills and s_tready drops once both entries are taken.
// Reset: the bus is released, the sequencer is idle, presence is cleared and
// the timing registers take their default values.
// Depends on owbm_pkg, owbm_front, owbm_queue and owbm_back.
module one_wire_bus_master_top
    import owbm_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // data_byte[7:0], line_level[8], zero[15:9]
    input  logic [2:0]           s_tuser,   // mode[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                            // presence[3], read_value[11:4],
                                            // rejected[12], zero[15:13]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    item_t   front_item;
    item_t   queue_item;
    logic    queue_valid;
    logic    queue_pop;
    result_t result;

    // Classify the incoming transaction.
    owbm_front u_front
    (
        .mode       (s_tuser),
        .data_byte  (s_tdata[7:0]),
        .line_level (s_tdata[8]),
        .item       (front_item)
    );

    // Decouple the classifier from the sequencer.
    owbm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_en     (queue_pop),
        .pop_item   (queue_item)
    );

    // Run the bus phases and register the result.
    owbm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_pop   (queue_pop),
        .res_valid  (m_tvalid),
        .res        (result),
        .res_ready  (m_tready)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {3'b000, result.rejected, result.read_value, result.presence,
                      result.done_res, result.busy_res, result.drive_low};

endmodule

@@ rtl/core/owbm_checker.sv @@
// Port-level checks for the single-wire bus master, attached by bind.
// Depends only on the top level's ports.
module owbm_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The bus is only pulled low while a command is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("drive_low without busy");

    // A completed command leaves the sequencer idle and is never reported as rejected.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[12])
        else $error("done while busy or rejected");

    // A rejected command is only reported while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |-> m_tdata[1])
        else $error("rejected while idle");

    // Read data is only reported when a read completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:4] != 8'd0) |-> m_tdata[2])
        else $error("read value without done");

endmodule

bind one_wire_bus_master_top owbm_port_checker u_owbm_port_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/owbm_checker.sv @@
// Checker for the single-wire bus master: watches the input stream, the result stream
// and the register port, predicts every result and compares it with the block's output.
// Depends on owbm_pkg for the mode codes, the register map and the result fields.
module owbm_checker
    import owbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,   // data_byte[7:0], line_level[8], zero[15:9]
    input  logic [2:0]           s_tuser,   // mode[2:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                            // presence[3], read_value[11:4],
                                            // rejected[12], zero[15:13]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   errors,
    output int                   pending,
    output logic                 bus_busy
);

    localparam int COUNT_WIDTH = 10;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_RST_TAIL,
        SEQ_SLOT_LOW,
        SEQ_SLOT_WAIT,
        SEQ_SLOT_TAIL
    } seq_phase_t;

    typedef enum logic [1:0] {
        JOB_BUS_RESET,
        JOB_WRITE,
        JOB_READ_BYTE,
        JOB_READ_BIT
    } bus_job_t;

    // Shadow of the timing registers and of the sequencer state
    logic [CFG_W-1:0]       timing [CFG_COUNT];
    seq_phase_t             seq;
    logic [COUNT_WIDTH-1:0] tick_cnt;
    logic [7:0]             shift_reg;
    logic [3:0]             bits_left;
    bus_job_t               job;
    logic                   presence_seen;

    // Results predicted for accepted items, oldest first
    result_t due_results [$];

    // One line per mismatch, and the count goes up.
    task automatic report(input string what, input logic [15:0] exp_v, input logic [15:0] got_v);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, exp_v, got_v);
        errors++;
    endtask

    function automatic int at_least_one(input logic [CFG_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int write_low_len();
        return at_least_one(shift_reg[0] ? timing[CFG_WRITE_ONE_LOW] : timing[CFG_WRITE_ZERO_LOW]);
    endfunction

    // Length in ticks of the phase the sequencer is in now
    function automatic int phase_len();
        int lo;
        lo = write_low_len();
        case (seq)
            SEQ_RST_LOW:  return at_least_one(timing[CFG_RESET_LOW]);
            SEQ_RST_WAIT: return at_least_one(timing[CFG_PRESENCE_WAIT]);
            SEQ_RST_TAIL: return int'(timing[CFG_RESET_TAIL]);
            SEQ_SLOT_LOW:
                return (job == JOB_WRITE) ? lo : at_least_one(timing[CFG_READ_LOW]);
            SEQ_SLOT_WAIT:
            begin
                if (job == JOB_WRITE)
                    return (int'(timing[CFG_WRITE_SLOT]) > lo) ? int'(timing[CFG_WRITE_SLOT]) - lo : 0;
                return int'(timing[CFG_READ_SAMPLE]);
            end
            SEQ_SLOT_TAIL: return int'(READ_TAIL_TICKS);
            default:      return 0;
        endcase
    endfunction

    function automatic void enter_phase(input seq_phase_t p);
        seq      = p;
        tick_cnt = '0;
    endfunction

    // End of one bit slot; true when the whole command is over.
    function automatic logic finish_bit();
        if (job == JOB_WRITE)
            shift_reg = shift_reg >> 1;
        bits_left = bits_left - 4'd1;
        if (bits_left == 4'd0)
        begin
            enter_phase(SEQ_IDLE);
            return 1'b1;
        end
        enter_phase(SEQ_SLOT_LOW);
        return 1'b0;
    endfunction

    // Close every phase whose time is up; phases of length zero fall through on the same item.
    function automatic logic run_due_phases(input logic lvl);
        logic complete;
        logic halt;
        complete = 1'b0;
        halt     = 1'b0;
        while (!halt)
        begin
            if (seq == SEQ_IDLE || int'(tick_cnt) < phase_len())
                halt = 1'b1;
            else
            begin
                case (seq)
                    SEQ_RST_LOW:  enter_phase(SEQ_RST_WAIT);
                    SEQ_RST_WAIT:
                    begin
                        presence_seen = ~lvl;
                        enter_phase(SEQ_RST_TAIL);
                    end
                    SEQ_RST_TAIL:
                    begin
                        enter_phase(SEQ_IDLE);
                        complete = 1'b1;
                        halt     = 1'b1;
                    end
                    SEQ_SLOT_LOW: enter_phase(SEQ_SLOT_WAIT);
                    SEQ_SLOT_WAIT:
                    begin
                        if (job == JOB_WRITE)
                        begin
                            complete = finish_bit();
                            halt     = complete;
                        end
                        else
                        begin
                            if (job == JOB_READ_BIT)
                                shift_reg = {7'd0, lvl};
                            else
                                shift_reg = {lvl, shift_reg[7:1]};
                            enter_phase(SEQ_SLOT_TAIL);
                        end
                    end
                    default:
                    begin
                        complete = finish_bit();
                        halt     = complete;
                    end
                endcase
            end
        end
        return complete;
    endfunction

    // Advance the shadow sequencer by one input item and build its result.
    function automatic result_t predict_bus_step(input logic [2:0] mode, input logic [7:0] data,
                                                 input logic lvl);
        result_t r;
        cmd_t    kind;
        logic    was_busy;
        logic    complete;
        kind     = (mode > MODE_RBIT) ? CMD_TICK : cmd_t'(mode);
        was_busy = (seq != SEQ_IDLE);
        complete = 1'b0;
        r        = '0;
        if (kind != CMD_TICK)
        begin
            if (was_busy)
                r.rejected = 1'b1;
            else
            begin
                case (kind)
                    CMD_RESET:
                    begin
                        job           = JOB_BUS_RESET;
                        presence_seen = 1'b0;
                        bits_left     = 4'd0;
                        enter_phase(SEQ_RST_LOW);
                    end
                    CMD_WBYTE:
                    begin
                        job       = JOB_WRITE;
                        shift_reg = data;
                        bits_left = BYTE_BITS;
                        enter_phase(SEQ_SLOT_LOW);
                    end
                    CMD_RBYTE:
                    begin
                        job       = JOB_READ_BYTE;
                        shift_reg = 8'd0;
                        bits_left = BYTE_BITS;
                        enter_phase(SEQ_SLOT_LOW);
                    end
                    CMD_WBIT:
                    begin
                        job       = JOB_WRITE;
                        shift_reg = {7'd0, data[0]};
                        bits_left = 4'd1;
                        enter_phase(SEQ_SLOT_LOW);
                    end
                    default:
                    begin
                        job       = JOB_READ_BIT;
                        shift_reg = 8'd0;
                        bits_left = 4'd1;
                        enter_phase(SEQ_SLOT_LOW);
                    end
                endcase
                complete = run_due_phases(lvl);
            end
        end
        else if (was_busy)
        begin
            tick_cnt = tick_cnt + 1'b1;
            complete = run_due_phases(lvl);
        end
        r.drive_low  = (seq == SEQ_RST_LOW || seq == SEQ_SLOT_LOW);
        r.busy_res   = (seq != SEQ_IDLE);
        r.done_res   = complete;
        r.presence   = presence_seen;
        r.read_value = (complete && (job == JOB_READ_BYTE || job == JOB_READ_BIT)) ? shift_reg : 8'd0;
        return r;
    endfunction

    // Compare results first, then predict for the accepted input, then apply register writes.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
                timing[i] = CFG_DEFAULTS[i];
            seq           = SEQ_IDLE;
            tick_cnt      = '0;
            shift_reg     = 8'd0;
            bits_left     = 4'd0;
            job           = JOB_BUS_RESET;
            presence_seen = 1'b0;
            due_results.delete();
            pending       = 0;
            bus_busy      = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                    report("result with nothing due", 16'd0, m_tdata);
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[0] !== want.drive_low)
                        report("drive_low", 16'(want.drive_low), 16'(m_tdata[0]));
                    if (m_tdata[1] !== want.busy_res)
                        report("busy_res", 16'(want.busy_res), 16'(m_tdata[1]));
                    if (m_tdata[2] !== want.done_res)
                        report("done_res", 16'(want.done_res), 16'(m_tdata[2]));
                    if (m_tdata[3] !== want.presence)
                        report("presence", 16'(want.presence), 16'(m_tdata[3]));
                    if (m_tdata[11:4] !== want.read_value)
                        report("read_value", 16'(want.read_value), 16'(m_tdata[11:4]));
                    if (m_tdata[12] !== want.rejected)
                        report("rejected", 16'(want.rejected), 16'(m_tdata[12]));
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(predict_bus_step(s_tuser, s_tdata[7:0], s_tdata[8]));
            if (cfg_we)
                timing[cfg_idx] = cfg_wdata;
            pending  = due_results.size();
            bus_busy = (seq != SEQ_IDLE);
        end
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the single-wire bus master: clock, reset, stimulus, register
// programming, random stalls on both streams and the final verdict.
// Depends on owbm_pkg, one_wire_bus_master_top and owbm_checker.
module tb;
    import owbm_pkg::*;

    localparam longint RUN_LIMIT = 64'd4_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = 16'd0;  // data_byte[7:0], line_level[8], zero[15:9]
    logic [2:0]           s_tuser   = MODE_TICK;  // mode[2:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;   // drive_low[0], busy_res[1], done_res[2], presence[3],
                                     // read_value[11:4], rejected[12], zero[15:13]
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int   errors;
    int   pending;
    logic bus_busy;

    // Idle percentages of the sender and the receiver, and items sent so far
    int gap_pct    = 6;
    int stall_pct  = 70;
    int sent_items = 0;

    // Timing values as last programmed
    logic [CFG_W-1:0] cur_timing [CFG_COUNT];

    one_wire_bus_master_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    owbm_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .bus_busy  (bus_busy)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls at random.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Hard stop in case the run hangs.
    initial
    begin
        #(RUN_LIMIT);
        $display("one_wire_bus_master_top verification failed");
        $finish;
    end

    function automatic int min_one(input logic [CFG_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Upper bound in ticks of one command under the current timing.
    function automatic int op_ticks(input logic [2:0] mode);
        int bit_len;
        int read_len;
        bit_len = int'(cur_timing[CFG_WRITE_SLOT]);
        if (min_one(cur_timing[CFG_WRITE_ONE_LOW]) > bit_len)
            bit_len = min_one(cur_timing[CFG_WRITE_ONE_LOW]);
        if (min_one(cur_timing[CFG_WRITE_ZERO_LOW]) > bit_len)
            bit_len = min_one(cur_timing[CFG_WRITE_ZERO_LOW]);
        read_len = min_one(cur_timing[CFG_READ_LOW]) + int'(cur_timing[CFG_READ_SAMPLE])
                   + int'(READ_TAIL_TICKS);
        case (mode)
            MODE_RESET: return min_one(cur_timing[CFG_RESET_LOW])
                               + min_one(cur_timing[CFG_PRESENCE_WAIT])
                               + int'(cur_timing[CFG_RESET_TAIL]);
            MODE_WBYTE: return int'(BYTE_BITS) * bit_len;
            MODE_RBYTE: return int'(BYTE_BITS) * read_len;
            MODE_WBIT:  return bit_len;
            MODE_RBIT:  return read_len;
            default:    return 0;
        endcase
    endfunction

    // One input transaction, with an optional gap first; returns at the accepting edge.
    task automatic send_item(input logic [2:0] mode, input logic [7:0] data, input logic lvl);
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tuser  <= mode;
        s_tdata  <= {7'd0, lvl, data};
        s_tvalid <= 1'b1;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        sent_items++;
    endtask

    // A command followed by ticks; line_sel 0 or 1 holds the line, 2 makes it random.
    // Now and then a stray command replaces a tick.
    task automatic run_op(input logic [2:0] mode, input logic [7:0] data, input int line_sel,
                          input int ticks, input int noise_pct);
        logic lvl;
        lvl = (line_sel > 1) ? 1'($urandom) : 1'(line_sel);
        send_item(mode, data, lvl);
        for (int i = 0; i < ticks; i++)
        begin
            lvl = (line_sel > 1) ? 1'($urandom) : 1'(line_sel);
            if ($urandom_range(99) < noise_pct)
                send_item(3'($urandom_range(1, 7)), 8'($urandom), lvl);
            else
                send_item(MODE_TICK, 8'($urandom), lvl);
        end
    endtask

    // Tick until every result is in and the bus operation is over.
    task automatic drain_bus();
        logic busy_now;
        busy_now = 1'b1;
        while (busy_now)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while (pending != 0) @(negedge clk);
            busy_now = bus_busy;
            @(posedge clk);
            if (busy_now)
                send_item(MODE_TICK, 8'($urandom), 1'($urandom));
        end
        repeat (4) @(posedge clk);
    endtask

    // Write every timing register from cur_timing, one per cycle.
    task automatic load_timing();
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_idx   <= CFG_IDX_W'(i);
            cfg_wdata <= cur_timing[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed commands with enough ticks to finish; some cut short so the
    // next command is refused, plus idle ticks and unused mode codes.
    task automatic random_traffic(input int budget);
        int         stop_at;
        int         pick;
        int         ticks;
        logic [2:0] mode;
        stop_at = sent_items + budget;
        while (sent_items < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                mode = MODE_RESET;
            else if (pick < 42)
                mode = MODE_WBYTE;
            else if (pick < 47)
                mode = MODE_RBYTE;
            else if (pick < 67)
                mode = MODE_WBIT;
            else
                mode = MODE_RBIT;
            if (pick >= 87)
                run_op((pick < 94) ? MODE_TICK : 3'($urandom_range(6, 7)), 8'($urandom), 2,
                       $urandom_range(0, 3), 0);
            else
            begin
                ticks = op_ticks(mode) + $urandom_range(0, 2);
                if ($urandom_range(99) < 12)
                    ticks = $urandom_range(0, ticks);
                run_op(mode, 8'($urandom), 2, ticks, 4);
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < CFG_COUNT; i++)
            cur_timing[i] = CFG_DEFAULTS[i];

        // Timing after reset: one write-one slot.
        run_op(MODE_WBIT, 8'hFF, 1, op_ticks(MODE_WBIT), 0);
        drain_bus();

        // Short fixed timing for the directed part.
        cur_timing[CFG_RESET_LOW]      = 10'd2;
        cur_timing[CFG_PRESENCE_WAIT]  = 10'd2;
        cur_timing[CFG_RESET_TAIL]     = 10'd1;
        cur_timing[CFG_WRITE_ONE_LOW]  = 10'd1;
        cur_timing[CFG_WRITE_ZERO_LOW] = 10'd3;
        cur_timing[CFG_WRITE_SLOT]     = 10'd4;
        cur_timing[CFG_READ_LOW]       = 10'd1;
        cur_timing[CFG_READ_SAMPLE]    = 10'd1;
        load_timing();

        // Idle ticks and the unused mode codes.
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(3'd6, 8'hFF, 1'b1);
        send_item(3'd7, 8'h00, 1'b0);
        // Reset with and without a device answering.
        run_op(MODE_RESET, 8'h00, 0, op_ticks(MODE_RESET), 0);
        run_op(MODE_RESET, 8'hFF, 1, op_ticks(MODE_RESET), 0);
        // Byte and bit writes with extreme data.
        run_op(MODE_WBYTE, 8'h00, 0, op_ticks(MODE_WBYTE), 0);
        run_op(MODE_WBYTE, 8'hFF, 1, op_ticks(MODE_WBYTE), 0);
        run_op(MODE_WBIT, 8'hFE, 1, op_ticks(MODE_WBIT), 0);
        run_op(MODE_WBIT, 8'h01, 0, op_ticks(MODE_WBIT), 0);
        // A byte read with the line held high, then bit reads with the line high and low.
        run_op(MODE_RBYTE, 8'h00, 1, op_ticks(MODE_RBYTE), 0);
        run_op(MODE_RBIT, 8'h00, 1, op_ticks(MODE_RBIT), 0);
        run_op(MODE_RBIT, 8'hFF, 0, op_ticks(MODE_RBIT), 0);
        // A bit write starts a slot, then commands while busy are refused; an unused code while busy is a tick.
        send_item(MODE_WBIT, 8'h01, 1'b1);
        send_item(MODE_RESET, 8'h00, 1'b0);
        send_item(MODE_RBYTE, 8'hFF, 1'b1);
        send_item(3'd7, 8'h00, 1'b1);
        drain_bus();

        // Random short timing.
        for (int i = 0; i < CFG_COUNT; i++)
            cur_timing[i] = CFG_W'($urandom_range(1, 4));
        cur_timing[CFG_RESET_TAIL]  = CFG_W'($urandom_range(0, 3));
        cur_timing[CFG_READ_SAMPLE] = CFG_W'($urandom_range(0, 3));
        cur_timing[CFG_WRITE_SLOT]  = CFG_W'($urandom_range(2, 6));
        load_timing();
        random_traffic(300);
        drain_bus();

        // All registers zero: minimal low times, a zero-length reset tail and read sample.
        gap_pct   = 70;
        stall_pct = 6;
        for (int i = 0; i < CFG_COUNT; i++)
            cur_timing[i] = '0;
        load_timing();
        random_traffic(250);
        drain_bus();

        // Moderate random timing.
        for (int i = 0; i < CFG_COUNT; i++)
            cur_timing[i] = CFG_W'($urandom_range(0, 40));
        load_timing();
        random_traffic(200);
        drain_bus();

        // Write slot shorter than the write-zero low time, with both streams at full rate.
        gap_pct   = 0;
        stall_pct = 0;
        for (int i = 0; i < CFG_COUNT; i++)
            cur_timing[i] = CFG_W'($urandom_range(1, 12));
        cur_timing[CFG_WRITE_ZERO_LOW] = 10'd9;
        cur_timing[CFG_WRITE_SLOT]     = 10'd2;
        load_timing();
        random_traffic(200);
        drain_bus();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("one_wire_bus_master_top verification clean");
        else
            $display("one_wire_bus_master_top verification failed");
        $finish;
    end

endmodule
